@@ hw/rtl/np_pkg.sv @@
`default_nettype none

package np_pkg;

  // Field and state widths.
  localparam int CH_W    = 8;
  localparam int NOTE_W  = 7;
  localparam int SEMI_W  = 4;
  localparam int ACC_W   = 2;
  localparam int OCT_W   = 4;
  localparam int PHASE_W = 3;
  localparam int SUM_W   = 8;

  // Parse phases.
  localparam logic [PHASE_W-1:0] PH_LEAD   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LETTER = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ACC    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_TRAIL  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BAD    = 3'd4;

  // Configuration register indexes.
  localparam logic REG_MIN_NOTE = 1'b0;
  localparam logic REG_MAX_NOTE = 1'b1;

  // Reset values.
  localparam logic [NOTE_W-1:0] RESET_MIN_NOTE = 7'd12;
  localparam logic [NOTE_W-1:0] RESET_MAX_NOTE = 7'd108;
  localparam logic [OCT_W-1:0]  DEFAULT_OCT    = 4'd4;

  // Accidental offsets in two's complement.
  localparam logic [ACC_W-1:0] ACC_NONE  = 2'd0;
  localparam logic [ACC_W-1:0] ACC_SHARP = 2'd1;
  localparam logic [ACC_W-1:0] ACC_FLAT  = 2'd3;

  // Character codes.
  localparam logic [CH_W-1:0] CHR_NUL     = 8'h00;
  localparam logic [CH_W-1:0] CHR_TAB     = 8'h09;
  localparam logic [CH_W-1:0] CHR_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CHR_HASH    = 8'h23;
  localparam logic [CH_W-1:0] CHR_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CHR_NINE    = 8'h39;
  localparam logic [CH_W-1:0] CHR_UP_A    = 8'h41;
  localparam logic [CH_W-1:0] CHR_UP_B    = 8'h42;
  localparam logic [CH_W-1:0] CHR_UP_G    = 8'h47;
  localparam logic [CH_W-1:0] CHR_LO_A    = 8'h61;
  localparam logic [CH_W-1:0] CHR_LO_B    = 8'h62;
  localparam logic [CH_W-1:0] CHR_LO_S    = 8'h73;
  localparam logic [CH_W-1:0] CHR_LO_Z    = 8'h7A;
  localparam logic [CH_W-1:0] CASE_OFFSET = 8'h20;

  // Parser state carried from one character to the next.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [SEMI_W-1:0]  semi;
    logic [ACC_W-1:0]   acc;
    logic [OCT_W-1:0]   oct;
  } np_state_t;

  localparam np_state_t STATE_RESET = '{
    phase: PH_LEAD,
    semi:  4'd0,
    acc:   ACC_NONE,
    oct:   DEFAULT_OCT
  };

  // Semitone of letters A through G, indexed from A.
  function automatic logic [SEMI_W-1:0] letter_semi(input logic [2:0] idx);
    logic [SEMI_W-1:0] s;
    case (idx)
      3'd0:    s = 4'd9;
      3'd1:    s = 4'd11;
      3'd2:    s = 4'd0;
      3'd3:    s = 4'd2;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd5;
      3'd6:    s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/note_name_parser_core.sv @@
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   ch
// output    out        out_valid/out_stall midi_note, ok
// config    in         cfg_we              cfg_index, cfg_data
//
// One character per cycle is taken while the input is not stalled: the character
// waits in the input register, then the parse step updates the parser state,
// and a terminator loads the result register.
// Reset (rst, synchronous) empties both registers, restores the limits to 12
// and 108 and puts the parser in its leading-blank phase.
// A stalled result holds the terminator in the input register; other
// characters keep flowing, and the input stalls only behind a held terminator.
module note_name_parser_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [np_pkg::CH_W-1:0]      ch,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [np_pkg::NOTE_W-1:0]         midi_note,
  output logic                              ok,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [np_pkg::NOTE_W-1:0]    cfg_data
);

  logic                         s1_valid;
  logic [np_pkg::CH_W-1:0]      ch_q;
  logic                         s1_adv;
  logic                         out_load;
  logic [np_pkg::NOTE_W-1:0]    min_note;
  logic [np_pkg::NOTE_W-1:0]    max_note;
  np_pkg::np_state_t            state;
  np_pkg::np_state_t            state_next;
  logic                         is_term;
  logic [np_pkg::NOTE_W-1:0]    step_note;
  logic                         step_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_note <= np_pkg::RESET_MIN_NOTE;
      max_note <= np_pkg::RESET_MAX_NOTE;
    end else if (cfg_we) begin
      if (cfg_index == np_pkg::REG_MIN_NOTE) begin
        min_note <= cfg_data;
      end else begin
        max_note <= cfg_data;
      end
    end
  end

  np_step u_step (
    .ch         (ch_q),
    .state      (state),
    .min_note   (min_note),
    .max_note   (max_note),
    .state_next (state_next),
    .is_term    (is_term),
    .midi_note  (step_note),
    .ok         (step_ok)
  );

  // A character leaves the input register unless it is a terminator that
  // finds the result register full and stalled.
  assign s1_adv   = s1_valid && (!is_term || !out_valid || !out_stall);
  assign out_load = s1_adv && is_term;
  assign in_stall = s1_valid && !s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      ch_q <= ch;
    end
  end

  // Parser state advances with each character that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= np_pkg::STATE_RESET;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      midi_note <= step_note;
      ok        <= step_ok;
    end
  end

`ifndef ASSERT_OFF
  // A rejected name never carries a note number.
  a_zero_when_bad : assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> midi_note == '0)
    else $error("result without ok carries a nonzero note");

  // The input stalls only while a character waits in the input register.
  a_stall_needs_item : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

  // A terminator that moves on restarts the parser and fills the result.
  a_term_restarts : assert property (@(posedge clk) disable iff (rst)
    s1_adv && is_term |=> state.phase == np_pkg::PH_LEAD && out_valid)
    else $error("terminator did not restart the parser or load a result");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/np_step.sv @@
`default_nettype none

// One parse step: next parser state for a character, and the note result
// that a terminator produces.
module np_step (
  input  wire logic [np_pkg::CH_W-1:0]   ch,
  input  wire np_pkg::np_state_t         state,
  input  wire logic [np_pkg::NOTE_W-1:0] min_note,
  input  wire logic [np_pkg::NOTE_W-1:0] max_note,
  output np_pkg::np_state_t              state_next,
  output logic                           is_term,
  output logic [np_pkg::NOTE_W-1:0]      midi_note,
  output logic                           ok
);

  logic                        blank;
  logic                        digit;
  logic                        sharp;
  logic                        flat;
  logic [np_pkg::CH_W-1:0]     upper;
  logic                        letter;
  logic [np_pkg::CH_W-1:0]     letter_off;
  logic [np_pkg::CH_W-1:0]     digit_off;
  logic [np_pkg::SUM_W-1:0]    oct_ext;
  logic [np_pkg::SUM_W-1:0]    sum;
  logic                        parsed;
  logic                        in_range;

  // Character classes.
  assign blank  = (ch == np_pkg::CHR_SPACE) || (ch == np_pkg::CHR_TAB);
  assign digit  = (ch >= np_pkg::CHR_ZERO) && (ch <= np_pkg::CHR_NINE);
  assign sharp  = (ch == np_pkg::CHR_HASH) || (ch == np_pkg::CHR_LO_S);
  assign flat   = (ch == np_pkg::CHR_LO_B) || (ch == np_pkg::CHR_UP_B);
  assign upper  = ((ch >= np_pkg::CHR_LO_A) && (ch <= np_pkg::CHR_LO_Z)) ?
                  ch - np_pkg::CASE_OFFSET : ch;
  assign letter = (upper >= np_pkg::CHR_UP_A) && (upper <= np_pkg::CHR_UP_G);
  assign letter_off = upper - np_pkg::CHR_UP_A;
  assign digit_off  = ch - np_pkg::CHR_ZERO;
  assign is_term    = (ch == np_pkg::CHR_NUL);

  // Phase transitions; a terminator always returns to the initial state.
  always_comb begin
    state_next = state;
    if (is_term) begin
      state_next = np_pkg::STATE_RESET;
    end else begin
      case (state.phase)
        np_pkg::PH_LEAD: begin
          if (!blank) begin
            if (letter) begin
              state_next.semi  = np_pkg::letter_semi(letter_off[2:0]);
              state_next.phase = np_pkg::PH_LETTER;
            end else begin
              state_next.phase = np_pkg::PH_BAD;
            end
          end
        end
        np_pkg::PH_LETTER: begin
          if (sharp) begin
            state_next.acc   = np_pkg::ACC_SHARP;
            state_next.phase = np_pkg::PH_ACC;
          end else if (flat) begin
            state_next.acc   = np_pkg::ACC_FLAT;
            state_next.phase = np_pkg::PH_ACC;
          end else if (digit) begin
            state_next.oct   = digit_off[np_pkg::OCT_W-1:0];
            state_next.phase = np_pkg::PH_TRAIL;
          end else if (blank) begin
            state_next.phase = np_pkg::PH_TRAIL;
          end else begin
            state_next.phase = np_pkg::PH_BAD;
          end
        end
        np_pkg::PH_ACC: begin
          if (digit) begin
            state_next.oct   = digit_off[np_pkg::OCT_W-1:0];
            state_next.phase = np_pkg::PH_TRAIL;
          end else if (blank) begin
            state_next.phase = np_pkg::PH_TRAIL;
          end else begin
            state_next.phase = np_pkg::PH_BAD;
          end
        end
        np_pkg::PH_TRAIL: begin
          if (!blank) begin
            state_next.phase = np_pkg::PH_BAD;
          end
        end
        default: begin
          state_next.phase = np_pkg::PH_BAD;
        end
      endcase
    end
  end

  // Note number: (octave + 1) * 12 + semitone + accidental. The octave times
  // twelve is two shifted copies; the smallest reachable sum is eleven.
  assign oct_ext = {{(np_pkg::SUM_W-np_pkg::OCT_W){1'b0}}, state.oct};
  assign sum = (oct_ext << 3) + (oct_ext << 2) + 8'd12
             + {{(np_pkg::SUM_W-np_pkg::SEMI_W){1'b0}}, state.semi}
             + {{(np_pkg::SUM_W-np_pkg::ACC_W){state.acc[np_pkg::ACC_W-1]}}, state.acc};

  assign parsed   = (state.phase == np_pkg::PH_LETTER) ||
                    (state.phase == np_pkg::PH_ACC) ||
                    (state.phase == np_pkg::PH_TRAIL);
  assign in_range = !sum[np_pkg::SUM_W-1] &&
                    (sum >= {1'b0, min_note}) && (sum <= {1'b0, max_note});
  assign ok        = parsed && in_range;
  assign midi_note = ok ? sum[np_pkg::NOTE_W-1:0] : '0;

endmodule

`default_nettype wire

@@ sim/note_name_parser_core_test.sv @@
`default_nettype none

module note_name_parser_core_test;
  import np_pkg::*;

  // Cycles to let the parse pipeline settle after the last expected note.
  localparam int SETTLE = 4;
  // Length of the long output hold that backs the block up.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any transfer before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Characters sent under each pair of limits.
  localparam int PHASE_CHARS = 130;

  typedef struct packed {
    logic [NOTE_W-1:0] midi_note;
    logic              ok;
  } note_result_t;

  // Tracks the parser state and the notes still owed by the block.
  class note_name_tracker;
    np_state_t         st;
    logic [NOTE_W-1:0] lo_limit;
    logic [NOTE_W-1:0] hi_limit;
    note_result_t      due_notes[$];
    int                mismatches;

    function new();
      st = STATE_RESET;
      lo_limit = RESET_MIN_NOTE;
      hi_limit = RESET_MAX_NOTE;
      mismatches = 0;
    endfunction

    function void set_limits(logic [NOTE_W-1:0] lo, logic [NOTE_W-1:0] hi);
      lo_limit = lo;
      hi_limit = hi;
    endfunction

    function int pending();
      return due_notes.size();
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Advances the parser by one accepted character; a terminator owes a note.
    task take_char(logic [CH_W-1:0] c);
      logic [SEMI_W-1:0] semitones [7] = '{4'd9, 4'd11, 4'd0, 4'd2, 4'd4, 4'd5, 4'd7};
      logic [CH_W-1:0]   up;
      logic              blank;
      logic              digit;
      int                oct_val;
      int                semi_val;
      int                acc_val;
      int                num;
      note_result_t      res;
      blank = (c == CHR_SPACE) || (c == CHR_TAB);
      digit = (c >= CHR_ZERO) && (c <= CHR_NINE);
      if (c == CHR_NUL) begin
        res = '0;
        if (st.phase == PH_LETTER || st.phase == PH_ACC || st.phase == PH_TRAIL) begin
          oct_val = st.oct;
          semi_val = st.semi;
          acc_val = $signed(st.acc);
          num = (oct_val + 1) * 12 + semi_val + acc_val;
          if (num >= int'(lo_limit) && num <= int'(hi_limit) && num <= 127) begin
            res.midi_note = num[NOTE_W-1:0];
            res.ok = 1'b1;
          end
        end
        due_notes.push_back(res);
        st = STATE_RESET;
      end else begin
        case (st.phase)
          PH_LEAD: begin
            if (!blank) begin
              up = (c >= CHR_LO_A && c <= CHR_LO_Z) ? c - CASE_OFFSET : c;
              if (up >= CHR_UP_A && up <= CHR_UP_G) begin
                st.semi = semitones[up - CHR_UP_A];
                st.phase = PH_LETTER;
              end else begin
                st.phase = PH_BAD;
              end
            end
          end
          PH_LETTER: begin
            if (c == CHR_HASH || c == CHR_LO_S) begin
              st.acc = ACC_SHARP;
              st.phase = PH_ACC;
            end else if (c == CHR_LO_B || c == CHR_UP_B) begin
              st.acc = ACC_FLAT;
              st.phase = PH_ACC;
            end else if (digit) begin
              st.oct = OCT_W'(c - CHR_ZERO);
              st.phase = PH_TRAIL;
            end else if (blank) begin
              st.phase = PH_TRAIL;
            end else begin
              st.phase = PH_BAD;
            end
          end
          PH_ACC: begin
            if (digit) begin
              st.oct = OCT_W'(c - CHR_ZERO);
              st.phase = PH_TRAIL;
            end else if (blank) begin
              st.phase = PH_TRAIL;
            end else begin
              st.phase = PH_BAD;
            end
          end
          PH_TRAIL: begin
            if (!blank) st.phase = PH_BAD;
          end
          default: begin
            st.phase = PH_BAD;
          end
        endcase
      end
    endtask

    // Compares one delivered note against the oldest one owed.
    task match_note(logic [NOTE_W-1:0] got_note, logic got_ok);
      note_result_t exp;
      if (due_notes.size() == 0) begin
        report($sformatf("note %0d ok %0b with nothing owed", got_note, got_ok));
      end else begin
        exp = due_notes.pop_front();
        if (got_note !== exp.midi_note)
          report($sformatf("midi_note %0d, expected %0d", got_note, exp.midi_note));
        if (got_ok !== exp.ok)
          report($sformatf("ok %0b, expected %0b", got_ok, exp.ok));
      end
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [CH_W-1:0]   ch;
  logic              out_valid;
  logic              out_stall;
  logic [NOTE_W-1:0] midi_note;
  logic              ok;
  logic              cfg_we;
  logic              cfg_index;
  logic [NOTE_W-1:0] cfg_data;

  note_name_tracker tracker = new();
  bit               no_gaps = 1'b0;
  bit               hold_req = 1'b0;
  int               quiet_cycles = 0;
  int               chars_sent = 0;

  note_name_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .midi_note (midi_note),
    .ok        (ok),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result checking, plus a watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.match_note(midi_note, ok);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: stalls a random number of cycles before each transfer.
  initial begin
    int hold;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = no_gaps ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one character after a random gap and waits for its transfer.
  task automatic send_char(input logic [CH_W-1:0] c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    do @(posedge clk); while (in_stall);
    tracker.take_char(c);
    chars_sent++;
  endtask

  task automatic send_name(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(CHR_NUL);
  endtask

  function automatic logic [CH_W-1:0] pick_blank();
    return $urandom_range(0, 1) ? CHR_SPACE : CHR_TAB;
  endfunction

  // Mostly well-formed names with random parts; some broken, some pure noise.
  task automatic send_random_name();
    logic [CH_W-1:0] name_q[$];
    logic [CH_W-1:0] letter;
    int              kind;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(0, 6)) name_q.push_back(CH_W'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) name_q.push_back(pick_blank());
      letter = CHR_UP_A + CH_W'($urandom_range(0, 6));
      if ($urandom_range(0, 1)) letter = letter + CASE_OFFSET;
      name_q.push_back(letter);
      case ($urandom_range(0, 4))
        1: name_q.push_back(CHR_HASH);
        2: name_q.push_back(CHR_LO_S);
        3: name_q.push_back(CHR_LO_B);
        4: name_q.push_back(CHR_UP_B);
        default: ;
      endcase
      if ($urandom_range(0, 3) != 0) name_q.push_back(CHR_ZERO + CH_W'($urandom_range(0, 9)));
      repeat ($urandom_range(0, 2)) name_q.push_back(pick_blank());
      // A stray character somewhere in the name.
      if (kind >= 7)
        name_q.insert($urandom_range(0, name_q.size()), CH_W'($urandom_range(1, 255)));
    end
    name_q.push_back(CHR_NUL);
    foreach (name_q[i]) send_char(name_q[i]);
  endtask

  // Writes both limits back to back; only called while the block is idle.
  task automatic set_limits(input logic [NOTE_W-1:0] lo, input logic [NOTE_W-1:0] hi);
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_NOTE;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_NOTE;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_limits(lo, hi);
  endtask

  // Waits until every owed note has arrived and the pipeline is empty.
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    logic [NOTE_W-1:0] lo_set [6];
    logic [NOTE_W-1:0] hi_set [6];
    lo_set = '{7'd0, 7'd60, 7'd100, 7'd127, 7'd11, 7'd24};
    hi_set = '{7'd127, 7'd72, 7'd20, 7'd127, 7'd11, 7'd96};
    rst <= 1'b1;
    in_valid <= 1'b0;
    ch <= CHR_NUL;
    cfg_we <= 1'b0;
    cfg_index <= REG_MIN_NOTE;
    cfg_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed names under the reset limits: empty, both reachable extremes,
    // blanks around a flat, a sharp spelled with s, and bad characters.
    send_name("");
    send_name("Cb0");
    send_name("B#9");
    send_name(" aB3\t");
    send_name("\tds1");
    send_name("Gx");
    send_char(8'hFF);
    send_name("D");
    drain();

    // Random names under several limit pairs, crossed and single-note ones too.
    foreach (lo_set[p]) begin
      set_limits(lo_set[p], hi_set[p]);
      no_gaps = (p == 3);
      hold_req = (p == 1);
      chars_sent = 0;
      while (chars_sent < PHASE_CHARS) send_random_name();
      drain();
    end

    if (tracker.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
